// ===== src/ita_pkg.sv =====
// ----------------------------------------------------------------------------
// ita_pkg: shared types and constants for the integer to ASCII converter
// Format codes, job descriptor and back-end state encoding.
// ----------------------------------------------------------------------------
package ita_pkg;

  localparam int unsigned NumDigits = 11;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned DecDigits = 10;
  localparam int unsigned BitCntW   = 5;
  localparam int unsigned IdxW      = 4;
  localparam int unsigned CountW    = 4;

  localparam logic [7:0] AsciiZero  = 8'h30;
  localparam logic [7:0] AsciiMinus = 8'h2D;

  typedef enum logic [1:0] {
    FUNC_SDEC = 2'd0,
    FUNC_UDEC = 2'd1,
    FUNC_OCT  = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_SIGN,
    ST_DIGIT
  } back_state_e;

  typedef struct packed {
    logic        neg;
    logic        octal;
    logic [31:0] mag;
  } job_t;

  typedef logic [NumDigits-1:0][DigitW-1:0] digits_t;

endpackage

// ===== src/ita_front.sv =====
// ----------------------------------------------------------------------------
// ita_front: input classifier
// Drops unused formats, forms the magnitude and sign, pushes a job.
// ----------------------------------------------------------------------------
module ita_front (
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    func_i,
  input  logic [31:0]   value_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output ita_pkg::job_t push_job_o
);

  ita_pkg::func_e func;

  assign func       = ita_pkg::func_e'(func_i);
  assign in_ready_o = push_ready_i;

  always_comb begin
    push_valid_o     = in_valid_i && (func != ita_pkg::FUNC_NONE);
    push_job_o.neg   = (func == ita_pkg::FUNC_SDEC) && value_i[31];
    push_job_o.octal = (func == ita_pkg::FUNC_OCT);
    push_job_o.mag   = push_job_o.neg ? (~value_i + 32'd1) : value_i;
  end

endmodule

// ===== src/ita_fifo.sv =====
// ----------------------------------------------------------------------------
// ita_fifo: job queue
// Small register queue between the classifier and the converter.
// ----------------------------------------------------------------------------
module ita_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  ita_pkg::job_t push_job_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output ita_pkg::job_t pop_job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ita_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_job_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// ===== src/ita_back.sv =====
// ----------------------------------------------------------------------------
// ita_back: digit converter and character emitter
// Shift-and-add-3 for decimal, bit grouping for octal, then emits the
// sign and significant digits through an output register.
// ----------------------------------------------------------------------------
module ita_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  ita_pkg::job_t job_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    character_o,
  output logic          last_o,
  output logic [3:0]    char_count_o
);

  ita_pkg::back_state_e state_q, state_d;

  ita_pkg::digits_t dig_q, dig_adj, dig_shift, dig_oct;
  logic [31:0] mag_q;
  logic neg_q;
  logic [ita_pkg::BitCntW-1:0] bit_cnt_q;
  logic [ita_pkg::IdxW-1:0]    idx_q, top;
  logic [ita_pkg::CountW-1:0]  total_q;

  logic out_valid_q, out_last_q;
  logic [7:0] out_char_q;
  logic [3:0] out_count_q;

  logic out_free, emit, emit_last;
  logic [7:0] emit_char;
  logic [3:0] emit_count;

  assign out_free = !out_valid_q || out_ready_i;

  // decimal: add 3 to every BCD digit of 5 or more, then shift in next bit
  always_comb begin
    dig_adj = dig_q;
    for (int i = 0; i < ita_pkg::DecDigits; i++) begin
      if (dig_q[i] >= 4'd5) begin
        dig_adj[i] = dig_q[i] + 4'd3;
      end
    end
    dig_shift = '0;
    dig_shift[0] = {dig_adj[0][2:0], mag_q[31]};
    for (int i = 1; i < ita_pkg::DecDigits; i++) begin
      dig_shift[i] = {dig_adj[i][2:0], dig_adj[i-1][3]};
    end
  end

  always_comb begin
    dig_oct = '0;
    for (int i = 0; i < ita_pkg::DecDigits; i++) begin
      dig_oct[i] = {1'b0, job_i.mag[3*i +: 3]};
    end
    dig_oct[ita_pkg::NumDigits-1] = {2'b00, job_i.mag[31:30]};
  end

  // most significant nonzero digit, zero when all digits are zero
  always_comb begin
    top = '0;
    for (int i = 1; i < ita_pkg::NumDigits; i++) begin
      if (dig_q[i] != '0) begin
        top = ita_pkg::IdxW'(i);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ita_pkg::ST_IDLE: begin
        if (job_valid_i) begin
          state_d = job_i.octal ? ita_pkg::ST_SIZE : ita_pkg::ST_CONV;
        end
      end
      ita_pkg::ST_CONV: begin
        if (bit_cnt_q == '1) begin
          state_d = ita_pkg::ST_SIZE;
        end
      end
      ita_pkg::ST_SIZE: begin
        state_d = neg_q ? ita_pkg::ST_SIGN : ita_pkg::ST_DIGIT;
      end
      ita_pkg::ST_SIGN: begin
        if (out_free) begin
          state_d = ita_pkg::ST_DIGIT;
        end
      end
      ita_pkg::ST_DIGIT: begin
        if (out_free && idx_q == '0) begin
          state_d = ita_pkg::ST_IDLE;
        end
      end
      default: state_d = ita_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    job_ready_o = 1'b0;
    emit        = 1'b0;
    emit_char   = ita_pkg::AsciiZero;
    emit_last   = 1'b0;
    emit_count  = '0;
    unique case (state_q)
      ita_pkg::ST_IDLE: job_ready_o = 1'b1;
      ita_pkg::ST_SIGN: begin
        emit      = out_free;
        emit_char = ita_pkg::AsciiMinus;
      end
      ita_pkg::ST_DIGIT: begin
        emit       = out_free;
        emit_char  = ita_pkg::AsciiZero + {4'b0000, dig_q[idx_q]};
        emit_last  = (idx_q == '0);
        emit_count = emit_last ? total_q : '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ita_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_char_q  <= emit_char;
      out_last_q  <= emit_last;
      out_count_q <= emit_count;
    end
    unique case (state_q)
      ita_pkg::ST_IDLE: begin
        if (job_valid_i) begin
          neg_q     <= job_i.neg;
          mag_q     <= job_i.mag;
          bit_cnt_q <= '0;
          dig_q     <= job_i.octal ? dig_oct : '0;
        end
      end
      ita_pkg::ST_CONV: begin
        dig_q     <= dig_shift;
        mag_q     <= {mag_q[30:0], 1'b0};
        bit_cnt_q <= bit_cnt_q + ita_pkg::BitCntW'(1);
      end
      ita_pkg::ST_SIZE: begin
        idx_q   <= top;
        total_q <= top + ita_pkg::CountW'(1) + ita_pkg::CountW'(neg_q);
      end
      ita_pkg::ST_DIGIT: begin
        if (out_free && idx_q != '0) begin
          idx_q <= idx_q - ita_pkg::IdxW'(1);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign character_o  = out_char_q;
  assign last_o       = out_last_q;
  assign char_count_o = out_count_q;

endmodule

// ===== src/integer_to_ascii_digits.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_digits: 32-bit integer to ASCII digit stream
// Signed decimal, unsigned decimal or octal text, most significant first.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) takes func_i and value_i. Format
// code 3 is accepted and produces nothing. Output channel
// (out_valid_o/out_ready_i) gives one character per transfer; last_o marks
// the final character of a number and char_count_o then holds the number
// of characters (1 to 11), zero otherwise.
// A small job queue sits between the input classifier and the converter,
// so the input keeps accepting while the converter is busy or stalled.
// Decimal: a load step, the shift-and-add-3 loop over all magnitude bits,
// a sizing step, then one character per cycle while the output is free.
// Octal skips the conversion loop: load, sizing, then the characters.
// The converter handles one number at a time; its 32-step BCD loop sets
// the sustained rate. A stalled receiver holds the output register and
// the converter waits; the queue then fills and in_ready_o drops.
// Reset empties the queue and the output register and idles the converter.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  character_o,
  output logic        last_o,
  output logic [3:0]  char_count_o
);

  logic          push_valid, push_ready, pop_valid, pop_ready;
  ita_pkg::job_t push_job, pop_job;

  ita_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .value_i      (value_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  ita_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  ita_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (pop_valid),
    .job_ready_o  (pop_ready),
    .job_i        (pop_job),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .character_o  (character_o),
    .last_o       (last_o),
    .char_count_o (char_count_o)
  );

endmodule

// ===== src/ita_checker.sv =====
// ----------------------------------------------------------------------------
// ita_checker: port-level checks for integer_to_ascii_digits
// Output stream framing and stall behavior.
// ----------------------------------------------------------------------------
module ita_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  character_o,
  input logic        last_o,
  input logic [3:0]  char_count_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(character_o)
      && $stable(last_o) && $stable(char_count_o))
    else $error("output changed while stalled");

  a_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> char_count_o == 4'd0)
    else $error("count set on a non-final character");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> char_count_o != 4'd0 && char_count_o <= 4'd11
      && character_o != ita_pkg::AsciiMinus)
    else $error("bad final character or count");

  a_run_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o)
    else $error("gap inside a character run");

endmodule

bind integer_to_ascii_digits ita_checker u_ita_checker (.*);

// ===== dv/integer_to_ascii_digits_tb.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_digits_tb: self-checking bench for the integer to ASCII block
// Numbers are offered on the input channel in signed decimal, unsigned decimal,
// octal and the unused format. Each accepted number is spelled out here, and
// every output transfer is checked against the oldest predicted character.
// The run goes through phases of sender idling, receiver stalls and a long
// receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits_tb;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned TailCycles = 100;

  typedef struct packed {
    ita_pkg::func_e fn;
    logic [31:0]    val;
  } number_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    logic [3:0] cnt;
  } text_char_t;

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [1:0]  func_i       = ita_pkg::FUNC_SDEC;
  logic [31:0] value_i      = '0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [7:0]  character_o;
  logic        last_o;
  logic [3:0]  char_count_o;

  number_t     number_q[$];
  text_char_t  text_q[$];
  number_t     next_num;
  text_char_t  want, seen;
  bit          in_taken      = 1'b0;
  bit          hold_go       = 1'b0;
  bit          hold_off      = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned errors        = 0;
  int unsigned cycles        = 0;

  integer_to_ascii_digits dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .func_i,
    .value_i,
    .out_valid_o,
    .out_ready_i,
    .character_o,
    .last_o,
    .char_count_o
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Expected text of one number, most significant character first.
  function automatic void spell_number(ita_pkg::func_e fn, logic [31:0] val);
    logic [7:0]  txt[$];
    logic [31:0] mag;
    int unsigned radix;
    text_char_t  c;
    if (fn == ita_pkg::FUNC_NONE) return;
    mag   = val;
    radix = (fn == ita_pkg::FUNC_OCT) ? 8 : 10;
    if (fn == ita_pkg::FUNC_SDEC && val[31]) mag = ~val + 32'd1;
    do begin
      txt.push_front(ita_pkg::AsciiZero + 8'(mag % radix));
      mag = mag / radix;
    end while (mag != 0);
    if (fn == ita_pkg::FUNC_SDEC && val[31]) txt.push_front(ita_pkg::AsciiMinus);
    foreach (txt[k]) begin
      c.ch  = txt[k];
      c.fin = (k == txt.size() - 1);
      c.cnt = c.fin ? 4'(txt.size()) : 4'd0;
      text_q.push_back(c);
    end
  endfunction

  // Sender: new payload only after the previous transfer or from idle.
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (number_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_num = number_q.pop_front();
        in_valid_i <= 1'b1;
        func_i     <= next_num.fn;
        value_i    <= next_num.val;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver
  always @(negedge clk_i) begin
    out_ready_i <= rst_ni && !hold_off && ($urandom_range(99) >= stall_pct);
  end

  // Long receiver hold-off
  initial begin
    wait (hold_go);
    hold_off = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Monitor
  always @(posedge clk_i) begin
    in_taken <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        spell_number(ita_pkg::func_e'(func_i), value_i);
      end
      if (out_valid_o && out_ready_i) begin
        seen = '{ch: character_o, fin: last_o, cnt: char_count_o};
        if (text_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer: expected none, got char %h last %b count %0d",
                   $time, seen.ch, seen.fin, seen.cnt);
        end else begin
          want = text_q.pop_front();
          if (seen !== want) begin
            errors++;
            $display("%0t: mismatch: expected char %h last %b count %0d,",
                     $time, want.ch, want.fin, want.cnt,
                     " got char %h last %b count %0d", seen.ch, seen.fin, seen.cnt);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic add_number(ita_pkg::func_e fn, logic [31:0] val);
    number_q.push_back(number_t'{fn: fn, val: val});
  endtask

  task automatic add_random(int unsigned n);
    logic [31:0]    v;
    int unsigned    r;
    ita_pkg::func_e fn;
    repeat (n) begin
      case ($urandom_range(3))
        0: v = $urandom;
        1: v = $urandom >> $urandom_range(31);
        2: v = $urandom_range(20);
        default: v = ~($urandom >> $urandom_range(31));
      endcase
      r  = $urandom_range(15);
      fn = (r == 15) ? ita_pkg::FUNC_NONE : ita_pkg::func_e'(2'(r % 3));
      add_number(fn, v);
    end
  endtask

  task automatic drain();
    while (number_q.size() != 0 || in_valid_i || text_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
    @(posedge clk_i);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // no idling, edge values first
    set_idling(0, 0);
    add_number(ita_pkg::FUNC_SDEC, 32'd0);
    add_number(ita_pkg::FUNC_UDEC, 32'd0);
    add_number(ita_pkg::FUNC_OCT,  32'd0);
    add_number(ita_pkg::FUNC_NONE, 32'd0);
    add_number(ita_pkg::FUNC_SDEC, 32'd1);
    add_number(ita_pkg::FUNC_SDEC, 32'd9);
    add_number(ita_pkg::FUNC_UDEC, 32'd10);
    add_number(ita_pkg::FUNC_SDEC, 32'h7FFF_FFFF);
    add_number(ita_pkg::FUNC_SDEC, 32'h8000_0000);
    add_number(ita_pkg::FUNC_SDEC, 32'h8000_0001);
    add_number(ita_pkg::FUNC_SDEC, 32'hFFFF_FFFF);
    add_number(ita_pkg::FUNC_UDEC, 32'hFFFF_FFFF);
    add_number(ita_pkg::FUNC_OCT,  32'hFFFF_FFFF);
    add_number(ita_pkg::FUNC_OCT,  32'd7);
    add_number(ita_pkg::FUNC_OCT,  32'd8);
    add_number(ita_pkg::FUNC_UDEC, 32'd999999999);
    add_number(ita_pkg::FUNC_UDEC, 32'd1000000000);
    add_number(ita_pkg::FUNC_NONE, 32'hFFFF_FFFF);
    add_number(ita_pkg::FUNC_NONE, 32'h5A5A_A5A5);
    add_number(ita_pkg::FUNC_UDEC, 32'h8000_0000);
    add_random(10);
    drain();

    set_idling(50, 0);
    add_random(20);
    drain();

    set_idling(0, 50);
    add_random(20);
    drain();

    set_idling(14, 14);
    add_random(20);
    drain();

    // long receiver hold-off while the sender keeps offering
    set_idling(0, 0);
    add_random(12);
    @(posedge clk_i);
    hold_go = 1'b1;
    drain();

    set_idling(14, 14);
    add_random(10);
    drain();

    repeat (TailCycles) @(posedge clk_i);
    if (errors == 0 && text_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/ita_pkg.sv
src/ita_front.sv
src/ita_fifo.sv
src/ita_back.sv
src/integer_to_ascii_digits.sv
src/ita_checker.sv
dv/integer_to_ascii_digits_tb.sv
